/* design/artg_pkg.sv */
// ----------------------------------------------------------------------------
// artg_pkg
// Shared sizes, microcode encoding and the control program of the aspect
// ratio and text grid block.
// ----------------------------------------------------------------------------
`default_nettype none

package artg_pkg;

  // Pixel size width and scale format
  localparam int SIZE_BITS           = 16;
  localparam int SCALE_BITS          = 16;
  localparam int SCALE_FRACTION_BITS = 8;
  localparam int ASPECT_BITS         = 16;
  localparam int COLUMNS_BITS        = 21;
  localparam int ROWS_BITS           = 20;
  localparam int COLUMN_SHIFT        = 3;
  localparam int ROW_SHIFT           = 4;

  // Product width: a shifted size times a scale, fraction bits still attached
  localparam int PROD_BITS = SIZE_BITS + SCALE_BITS;

  // Register indexes
  localparam logic REG_COLUMN_SCALE = 1'b0;
  localparam logic REG_ROW_SCALE    = 1'b1;

  // Microcode program
  localparam int PC_BITS = 4;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,       // take a transaction from the input
    OP_MUL,        // text grid products
    OP_DIV_AB,     // start a / b
    OP_EUCLID,     // a <= b, b <= remainder
    OP_DIV_WA,     // start w / gcd
    OP_SET_AW,
    OP_DIV_HA,     // start h / gcd
    OP_SET_AH,
    OP_SET_DEGEN,  // both sizes zero
    OP_SHOW        // load the output register
  } op_t;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_INPUT,
    C_B_ZERO,
    C_A_ZERO,
    C_DIV_BUSY,
    C_OUT_FULL
  } cond_t;

  typedef struct packed {
    op_t                 op;
    cond_t               cond;
    logic [PC_BITS-1:0]  target;
  } ctrl_t;

  // Step names
  localparam logic [PC_BITS-1:0] S_IDLE     = 4'd0;
  localparam logic [PC_BITS-1:0] S_TEST_B   = 4'd2;
  localparam logic [PC_BITS-1:0] S_DIV_WAIT = 4'd4;
  localparam logic [PC_BITS-1:0] S_GCD_DONE = 4'd6;
  localparam logic [PC_BITS-1:0] S_W_WAIT   = 4'd8;
  localparam logic [PC_BITS-1:0] S_H_WAIT   = 4'd11;
  localparam logic [PC_BITS-1:0] S_DEGEN    = 4'd13;
  localparam logic [PC_BITS-1:0] S_SHOW     = 4'd14;

  // Control store: jump to target when the condition holds, else next step
  function automatic ctrl_t ucode(input logic [PC_BITS-1:0] pc);
    ctrl_t w;
    begin
      w = '{op: OP_NONE, cond: C_NEVER, target: S_IDLE};
      case (pc)
        4'd0:    w = '{op: OP_LOAD,      cond: C_NO_INPUT, target: S_IDLE};
        4'd1:    w = '{op: OP_MUL,       cond: C_NEVER,    target: S_IDLE};
        4'd2:    w = '{op: OP_NONE,      cond: C_B_ZERO,   target: S_GCD_DONE};
        4'd3:    w = '{op: OP_DIV_AB,    cond: C_NEVER,    target: S_IDLE};
        4'd4:    w = '{op: OP_NONE,      cond: C_DIV_BUSY, target: S_DIV_WAIT};
        4'd5:    w = '{op: OP_EUCLID,    cond: C_ALWAYS,   target: S_TEST_B};
        4'd6:    w = '{op: OP_NONE,      cond: C_A_ZERO,   target: S_DEGEN};
        4'd7:    w = '{op: OP_DIV_WA,    cond: C_NEVER,    target: S_IDLE};
        4'd8:    w = '{op: OP_NONE,      cond: C_DIV_BUSY, target: S_W_WAIT};
        4'd9:    w = '{op: OP_SET_AW,    cond: C_NEVER,    target: S_IDLE};
        4'd10:   w = '{op: OP_DIV_HA,    cond: C_NEVER,    target: S_IDLE};
        4'd11:   w = '{op: OP_NONE,      cond: C_DIV_BUSY, target: S_H_WAIT};
        4'd12:   w = '{op: OP_SET_AH,    cond: C_ALWAYS,   target: S_SHOW};
        4'd13:   w = '{op: OP_SET_DEGEN, cond: C_NEVER,    target: S_IDLE};
        4'd14:   w = '{op: OP_SHOW,      cond: C_OUT_FULL, target: S_SHOW};
        4'd15:   w = '{op: OP_NONE,      cond: C_ALWAYS,   target: S_IDLE};
        default: w = '{op: OP_NONE,      cond: C_ALWAYS,   target: S_IDLE};
      endcase
      return w;
    end
  endfunction

endpackage

`default_nettype wire

/* design/artg_div.sv */
// ----------------------------------------------------------------------------
// artg_div
// Restoring divider, one quotient bit per cycle. Divisor must be nonzero.
// ----------------------------------------------------------------------------
`default_nettype none

module artg_div (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  input  wire logic [artg_pkg::SIZE_BITS-1:0] dividend,
  input  wire logic [artg_pkg::SIZE_BITS-1:0] divisor,
  output logic                                busy,
  output logic      [artg_pkg::SIZE_BITS-1:0] quot,
  output logic      [artg_pkg::SIZE_BITS-1:0] rem
);

  localparam int SB     = artg_pkg::SIZE_BITS;
  localparam int CNT_W  = $clog2(SB + 1);

  logic [SB-1:0]    dsor;
  logic [CNT_W-1:0] count;
  logic [SB:0]      rem_shift;
  logic [SB:0]      diff;

  // Trial subtract of the shifted partial remainder
  assign rem_shift = {rem, quot[SB-1]};
  assign diff      = rem_shift - {1'b0, dsor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      count <= CNT_W'(SB);
    end else if (busy) begin
      count <= count - 1'b1;
      if (count == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      dsor <= divisor;
      quot <= dividend;
      rem  <= '0;
    end else if (busy) begin
      if (!diff[SB]) begin
        rem  <= diff[SB-1:0];
        quot <= {quot[SB-2:0], 1'b1};
      end else begin
        rem  <= rem_shift[SB-1:0];
        quot <= {quot[SB-2:0], 1'b0};
      end
    end
  end

endmodule

`default_nettype wire

/* design/aspect_ratio_and_text_grid.sv */
// ----------------------------------------------------------------------------
// aspect_ratio_and_text_grid
// Reduces a screen size to its aspect ratio and computes the scaled text grid.
// ----------------------------------------------------------------------------
// One transaction in gives one transaction out. The aspect ratio is the size
// divided by its Euclidean gcd; columns are (width >> 3) * column_scale and
// rows are (height >> 4) * row_scale, both Q8.8 and truncated. When both sizes
// are zero the aspect is 0:0 and degenerate is set. Items are handled one at
// a time by a small microcoded sequencer around a shared bit-serial divider.
// Each Euclid remainder step and each of the two final divisions waits on
// the divider; the number of remainder steps is 0 to 23 for 16-bit sizes,
// and when both sizes are zero no division is run. An item also waits while
// the output register is full. A finished result sits in the output
// register, and the next input is taken while it waits. Scale registers
// are written through cfg_write/cfg_index/cfg_data and reset to 1.0.
`default_nettype none

module aspect_ratio_and_text_grid (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // configuration
  input  wire logic                              cfg_write,
  input  wire logic                              cfg_index,
  input  wire logic [artg_pkg::SCALE_BITS-1:0]   cfg_data,
  // input channel
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [artg_pkg::SIZE_BITS-1:0]    screen_width,
  input  wire logic [artg_pkg::SIZE_BITS-1:0]    screen_height,
  // output channel
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic      [artg_pkg::ASPECT_BITS-1:0]  aspect_width,
  output logic      [artg_pkg::ASPECT_BITS-1:0]  aspect_height,
  output logic      [artg_pkg::COLUMNS_BITS-1:0] text_columns,
  output logic      [artg_pkg::ROWS_BITS-1:0]    text_rows,
  output logic                                   degenerate
);

  localparam int SB  = artg_pkg::SIZE_BITS;
  localparam int PW  = artg_pkg::PROD_BITS;
  localparam int FB  = artg_pkg::SCALE_FRACTION_BITS;
  localparam int AB  = artg_pkg::ASPECT_BITS;
  localparam int CB  = artg_pkg::COLUMNS_BITS;
  localparam int RB  = artg_pkg::ROWS_BITS;

  logic [artg_pkg::SCALE_BITS-1:0] column_scale;
  logic [artg_pkg::SCALE_BITS-1:0] row_scale;

  logic [artg_pkg::PC_BITS-1:0]    pc;
  artg_pkg::ctrl_t                 cw;
  logic                            take_jump;

  logic [SB-1:0] w, h, a, b;
  logic [AB-1:0] aw, ah;
  logic [CB-1:0] cols;
  logic [RB-1:0] rows;
  logic          degen;

  logic          div_start;
  logic [SB-1:0] div_dividend, div_divisor;
  logic          div_busy;
  logic [SB-1:0] div_quot, div_rem;

  logic [PW-1:0] col_prod, row_prod;
  logic          out_free;

  // Scale registers
  always_ff @(posedge clk) begin
    if (rst) begin
      column_scale <= artg_pkg::SCALE_BITS'(1 << FB);
      row_scale    <= artg_pkg::SCALE_BITS'(1 << FB);
    end else if (cfg_write) begin
      case (cfg_index)
        artg_pkg::REG_COLUMN_SCALE: column_scale <= cfg_data;
        artg_pkg::REG_ROW_SCALE:    row_scale    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Control word and jump condition
  assign cw       = artg_pkg::ucode(pc);
  assign in_ready = (pc == artg_pkg::S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    case (cw.cond)
      artg_pkg::C_NEVER:    take_jump = 1'b0;
      artg_pkg::C_ALWAYS:   take_jump = 1'b1;
      artg_pkg::C_NO_INPUT: take_jump = !in_valid;
      artg_pkg::C_B_ZERO:   take_jump = (b == '0);
      artg_pkg::C_A_ZERO:   take_jump = (a == '0);
      artg_pkg::C_DIV_BUSY: take_jump = div_busy;
      artg_pkg::C_OUT_FULL: take_jump = !out_free;
      default:              take_jump = 1'b1;
    endcase
  end

  // Step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= artg_pkg::S_IDLE;
    end else if (take_jump) begin
      pc <= cw.target;
    end else begin
      pc <= pc + 1'b1;
    end
  end

  // Divider operand select
  always_comb begin
    div_start    = 1'b0;
    div_dividend = a;
    div_divisor  = b;
    case (cw.op)
      artg_pkg::OP_DIV_AB: begin
        div_start = 1'b1;
      end
      artg_pkg::OP_DIV_WA: begin
        div_start    = 1'b1;
        div_dividend = w;
        div_divisor  = a;
      end
      artg_pkg::OP_DIV_HA: begin
        div_start    = 1'b1;
        div_dividend = h;
        div_divisor  = a;
      end
      default: ;
    endcase
  end

  artg_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  // Text grid products
  assign col_prod = PW'(w >> artg_pkg::COLUMN_SHIFT) * PW'(column_scale);
  assign row_prod = PW'(h >> artg_pkg::ROW_SHIFT) * PW'(row_scale);

  // Datapath registers
  always_ff @(posedge clk) begin
    case (cw.op)
      artg_pkg::OP_LOAD: begin
        if (in_valid) begin
          w <= screen_width;
          h <= screen_height;
          a <= screen_width;
          b <= screen_height;
        end
      end
      artg_pkg::OP_MUL: begin
        cols  <= col_prod[FB +: CB];
        rows  <= row_prod[FB +: RB];
        degen <= 1'b0;
      end
      artg_pkg::OP_EUCLID: begin
        a <= b;
        b <= div_rem;
      end
      artg_pkg::OP_SET_AW:    aw <= AB'(div_quot);
      artg_pkg::OP_SET_AH:    ah <= AB'(div_quot);
      artg_pkg::OP_SET_DEGEN: begin
        aw    <= '0;
        ah    <= '0;
        degen <= 1'b1;
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cw.op == artg_pkg::OP_SHOW && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cw.op == artg_pkg::OP_SHOW && out_free) begin
      aspect_width  <= aw;
      aspect_height <= ah;
      text_columns  <= cols;
      text_rows     <= rows;
      degenerate    <= degen;
    end
  end

endmodule

`default_nettype wire
